// ===== rtl/postfix_expression_evaluator_defines.svh =====
// assertion macros for the postfix evaluator
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// same-cycle implication
`ifndef SYNTH
`define PFX_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("pfx assertion failed");
`else
`define PFX_ASSERT_IMP(lbl, ant, cons)
`endif

// next-cycle implication
`ifndef SYNTH
`define PFX_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("pfx assertion failed");
`else
`define PFX_ASSERT_NXT(lbl, ant, cons)
`endif

`endif

// ===== rtl/pfx_pkg.sv =====
`default_nettype none

package pfx_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

  localparam int OPW       = 32;
  localparam int DIV_CNT_W = $clog2(OPW);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_NONE
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RHS,
    S_LHS,
    S_MUL,
    S_DIV,
    S_ENDRD,
    S_EMIT
  } state_t;

  function automatic op_t decode_op(input logic [7:0] c);
    op_t op;
    unique case (c)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      default:  op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pfx_ifs.sv =====
`default_nettype none

// input channel: one character or end marker per transaction
interface pfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_marker;

  modport source (output valid, output character, output end_marker, input ready);
  modport sink   (input valid, input character, input end_marker, output ready);
endinterface

// result channel: final value and status per transaction
interface pfx_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/pfx_div.sv =====
`default_nettype none

`include "postfix_expression_evaluator_defines.svh"

// signed truncating divider, one quotient bit per cycle
module pfx_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [pfx_pkg::OPW-1:0] dividend,
  input  wire logic [pfx_pkg::OPW-1:0] divisor,
  output logic                         done,
  output logic [pfx_pkg::OPW-1:0]      quotient
);

  localparam logic [pfx_pkg::DIV_CNT_W-1:0] CNT_LAST = pfx_pkg::DIV_CNT_W'(pfx_pkg::OPW - 1);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic                          neg_r, neg_nxt;
  logic [pfx_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [pfx_pkg::OPW-1:0]       rem_r, rem_nxt;
  logic [pfx_pkg::OPW-1:0]       quo_r, quo_nxt;
  logic [pfx_pkg::OPW-1:0]       den_r, den_nxt;
  logic [pfx_pkg::OPW:0]         rem_shift;
  logic [pfx_pkg::OPW:0]         trial;
  logic                          na, nb;

  always_comb begin
    na        = dividend[pfx_pkg::OPW-1];
    nb        = divisor[pfx_pkg::OPW-1];
    rem_shift = {rem_r, quo_r[pfx_pkg::OPW-1]};
    trial     = rem_shift - {1'b0, den_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = na ? (pfx_pkg::OPW'(0) - dividend) : dividend;
      den_nxt  = nb ? (pfx_pkg::OPW'(0) - divisor) : divisor;
      neg_nxt  = na ^ nb;
    end else if (busy_r) begin
      if (!trial[pfx_pkg::OPW]) begin
        rem_nxt = trial[pfx_pkg::OPW-1:0];
        quo_nxt = {quo_r[pfx_pkg::OPW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_shift[pfx_pkg::OPW-1:0];
        quo_nxt = {quo_r[pfx_pkg::OPW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (pfx_pkg::OPW'(0) - quo_r) : quo_r;

  `PFX_ASSERT_IMP(a_start_idle, start, !busy_r)
  `PFX_ASSERT_NXT(a_last_step_done, busy_r && cnt_r == CNT_LAST, done_r && !busy_r)
  `PFX_ASSERT_IMP(a_done_not_busy, done_r, !busy_r)

endmodule

`default_nettype wire

// ===== rtl/postfix_expression_evaluator.sv =====
// postfix expression evaluator
// in_ch carries one ascii character per transaction; end_marker closes the
// expression and asks for its result. out_ch carries one transaction per
// expression: the final value and a status (ok, underflow, overflow, divide
// by zero); value is zero whenever status is not ok.
// operands live in a 16-entry stack ram with one write and one registered
// read port. sequencer path per character transaction:
//   digit, space, unknown character: taken in idle, no other state
//   + and -: idle, rhs read, lhs read (rhs read is skipped when a number is
//   still pending, its value is forwarded as the right operand), * adds mul
//   /: the div state, held until the one-bit-per-cycle divider is done
//   end: end read if the stack is read, then emit loads the output register
// the read port latency sets the add path; the divider sets the / path.
// in_ch.ready is high whenever the sequencer is idle, also while a result
// waits in the output register; an end transaction that finds the output
// register still full waits until out_ch.ready takes the old result.
// reset (synchronous, rst_n low) empties the stack, clears the number
// accumulator and the error; the ram itself needs no clearing pass, since
// only entries below the stack depth are ever read.
`default_nettype none

`include "postfix_expression_evaluator_defines.svh"

module postfix_expression_evaluator (
  input wire logic  clk,
  input wire logic  rst_n,
  pfx_in_if.sink    in_ch,
  pfx_out_if.source out_ch
);

  // stack ram
  logic [pfx_pkg::OPW-1:0]    stack_mem [pfx_pkg::STACK_DEPTH];
  logic                       mem_we;
  logic [pfx_pkg::ADDR_W-1:0] mem_waddr;
  logic [pfx_pkg::OPW-1:0]    mem_wdata;
  logic                       mem_re;
  logic [pfx_pkg::ADDR_W-1:0] mem_raddr;
  logic [pfx_pkg::OPW-1:0]    rd_data_r;

  // control state
  pfx_pkg::state_t             state_r, state_nxt;
  logic [pfx_pkg::DEPTH_W-1:0] depth_r, depth_nxt;
  logic [pfx_pkg::OPW-1:0]     acc_r, acc_nxt;
  logic                        pending_r, pending_nxt;
  pfx_pkg::status_t            err_r, err_nxt;
  pfx_pkg::op_t                op_r, op_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // payload registers
  logic [pfx_pkg::OPW-1:0] rhs_r, rhs_nxt;
  logic [pfx_pkg::OPW-1:0] prod_r, prod_nxt;
  logic [pfx_pkg::OPW-1:0] res_val_r, res_val_nxt;
  pfx_pkg::status_t        res_st_r, res_st_nxt;
  logic [pfx_pkg::OPW-1:0] out_value_r, out_value_nxt;
  pfx_pkg::status_t        out_st_r, out_st_nxt;

  // decode of the incoming character
  logic                        in_fire;
  logic                        is_digit;
  logic                        is_space;
  logic [7:0]                  digit_diff;
  pfx_pkg::op_t                op_dec;
  logic                        flush_ovf;
  logic [pfx_pkg::DEPTH_W-1:0] eff_depth;
  logic                        eff_lt2;
  logic                        out_free;
  logic [pfx_pkg::OPW-1:0]     acc_times10;

  // divider
  logic                    div_start;
  logic                    div_done;
  logic [pfx_pkg::OPW-1:0] div_quo;

  assign in_ch.ready = (state_r == pfx_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    digit_diff  = in_ch.character - pfx_pkg::CH_ZERO;
    is_digit    = (in_ch.character >= pfx_pkg::CH_ZERO) &&
                  (in_ch.character <= pfx_pkg::CH_NINE);
    is_space    = (in_ch.character == pfx_pkg::CH_SPACE);
    op_dec      = pfx_pkg::decode_op(in_ch.character);
    // pending number meets a full stack
    flush_ovf   = pending_r && (depth_r == pfx_pkg::DEPTH_FULL);
    eff_depth   = depth_r + pfx_pkg::DEPTH_W'(pending_r);
    eff_lt2     = (eff_depth < pfx_pkg::DEPTH_W'(2));
    // acc * 10 as two shifts and an add
    acc_times10 = {acc_r[pfx_pkg::OPW-4:0], 3'b000} + {acc_r[pfx_pkg::OPW-2:0], 1'b0};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfx_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.end_marker) begin
            if (err_r == pfx_pkg::ST_OK && !pending_r && depth_r != '0) begin
              state_nxt = pfx_pkg::S_ENDRD;
            end else begin
              state_nxt = pfx_pkg::S_EMIT;
            end
          end else if (err_r == pfx_pkg::ST_OK && !is_digit && !flush_ovf && !is_space &&
                       !eff_lt2 && op_dec != pfx_pkg::OP_NONE) begin
            state_nxt = pending_r ? pfx_pkg::S_LHS : pfx_pkg::S_RHS;
          end
        end
      end
      pfx_pkg::S_RHS: begin
        state_nxt = pfx_pkg::S_LHS;
      end
      pfx_pkg::S_LHS: begin
        case (op_r)
          pfx_pkg::OP_MUL: state_nxt = pfx_pkg::S_MUL;
          pfx_pkg::OP_DIV: state_nxt = (rhs_r == '0) ? pfx_pkg::S_IDLE : pfx_pkg::S_DIV;
          default:         state_nxt = pfx_pkg::S_IDLE;
        endcase
      end
      pfx_pkg::S_MUL: begin
        state_nxt = pfx_pkg::S_IDLE;
      end
      pfx_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = pfx_pkg::S_IDLE;
        end
      end
      pfx_pkg::S_ENDRD: begin
        state_nxt = pfx_pkg::S_EMIT;
      end
      pfx_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = pfx_pkg::S_IDLE;
        end
      end
      default: state_nxt = pfx_pkg::S_IDLE;
    endcase
  end

  // datapath and register updates
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = depth_r[pfx_pkg::ADDR_W-1:0];
    mem_wdata = acc_r;
    mem_re    = 1'b0;
    mem_raddr = pfx_pkg::ADDR_W'(depth_r - pfx_pkg::DEPTH_W'(1));
    div_start = 1'b0;

    depth_nxt     = depth_r;
    acc_nxt       = acc_r;
    pending_nxt   = pending_r;
    err_nxt       = err_r;
    op_nxt        = op_r;
    rhs_nxt       = rhs_r;
    prod_nxt      = prod_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_st_nxt    = out_st_r;

    unique case (state_r)
      pfx_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.end_marker) begin
            res_val_nxt = '0;
            res_st_nxt  = err_r;
            if (err_r == pfx_pkg::ST_OK) begin
              if (flush_ovf) begin
                res_st_nxt = pfx_pkg::ST_OVERFLOW;
              end else if (pending_r) begin
                // the pending number is the top of stack
                res_val_nxt = acc_r;
              end else if (depth_r == '0) begin
                res_st_nxt = pfx_pkg::ST_UNDERFLOW;
              end else begin
                mem_re = 1'b1;
              end
            end
            // whole expression state clears with the end transaction
            depth_nxt   = '0;
            acc_nxt     = '0;
            pending_nxt = 1'b0;
            err_nxt     = pfx_pkg::ST_OK;
          end else if (err_r != pfx_pkg::ST_OK) begin
            // sticky error: ignore until the end transaction
          end else if (is_digit) begin
            acc_nxt     = acc_times10 + pfx_pkg::OPW'(digit_diff[3:0]);
            pending_nxt = 1'b1;
          end else begin
            acc_nxt     = '0;
            pending_nxt = 1'b0;
            if (flush_ovf) begin
              err_nxt = pfx_pkg::ST_OVERFLOW;
            end else if (is_space) begin
              if (pending_r) begin
                mem_we    = 1'b1;
                depth_nxt = depth_r + 1'b1;
              end
            end else if (eff_lt2) begin
              err_nxt   = pfx_pkg::ST_UNDERFLOW;
              depth_nxt = '0;
            end else begin
              // pop two; an unknown character stops here
              depth_nxt = eff_depth - pfx_pkg::DEPTH_W'(2);
              if (op_dec != pfx_pkg::OP_NONE) begin
                op_nxt = op_dec;
                mem_re = 1'b1;
                if (pending_r) begin
                  // forward the pending number as right operand
                  rhs_nxt = acc_r;
                end
              end
            end
          end
        end
      end
      pfx_pkg::S_RHS: begin
        rhs_nxt   = rd_data_r;
        mem_re    = 1'b1;
        mem_raddr = depth_r[pfx_pkg::ADDR_W-1:0];
      end
      pfx_pkg::S_LHS: begin
        case (op_r)
          pfx_pkg::OP_ADD: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_r + rhs_r;
            depth_nxt = depth_r + 1'b1;
          end
          pfx_pkg::OP_SUB: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_r - rhs_r;
            depth_nxt = depth_r + 1'b1;
          end
          pfx_pkg::OP_MUL: begin
            prod_nxt = rd_data_r * rhs_r;
          end
          pfx_pkg::OP_DIV: begin
            if (rhs_r == '0) begin
              err_nxt = pfx_pkg::ST_DIVZERO;
            end else begin
              div_start = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      pfx_pkg::S_MUL: begin
        mem_we    = 1'b1;
        mem_wdata = prod_r;
        depth_nxt = depth_r + 1'b1;
      end
      pfx_pkg::S_DIV: begin
        if (div_done) begin
          mem_we    = 1'b1;
          mem_wdata = div_quo;
          depth_nxt = depth_r + 1'b1;
        end
      end
      pfx_pkg::S_ENDRD: begin
        res_val_nxt = rd_data_r;
        res_st_nxt  = pfx_pkg::ST_OK;
      end
      pfx_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_val_r;
          out_st_nxt    = res_st_r;
        end
      end
      default: begin
      end
    endcase
  end

  // stack ram ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= stack_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfx_pkg::S_IDLE;
      depth_r     <= '0;
      acc_r       <= '0;
      pending_r   <= 1'b0;
      err_r       <= pfx_pkg::ST_OK;
      op_r        <= pfx_pkg::OP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      acc_r       <= acc_nxt;
      pending_r   <= pending_nxt;
      err_r       <= err_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rhs_r       <= rhs_nxt;
    prod_r      <= prod_nxt;
    res_val_r   <= res_val_nxt;
    res_st_r    <= res_st_nxt;
    out_value_r <= out_value_nxt;
    out_st_r    <= out_st_nxt;
  end

  // iterative divider for the / operator
  pfx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data_r),
    .divisor  (rhs_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = $signed(out_value_r);
  assign out_ch.status = out_st_r;

  `PFX_ASSERT_IMP(a_depth_bound, 1'b1, depth_r <= pfx_pkg::DEPTH_FULL)
  `PFX_ASSERT_IMP(a_push_room, mem_we, depth_r < pfx_pkg::DEPTH_FULL)
  `PFX_ASSERT_NXT(a_end_clears, in_fire && in_ch.end_marker, depth_r == '0 && !pending_r && err_r == pfx_pkg::ST_OK)
  `PFX_ASSERT_IMP(a_result_from_emit, $rose(out_valid_r), $past(state_r) == pfx_pkg::S_EMIT)
  `PFX_ASSERT_NXT(a_div_returns_idle, state_r == pfx_pkg::S_DIV && div_done, state_r == pfx_pkg::S_IDLE)

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  // give up after this many cycles in which no transaction moves on either channel
  localparam int WATCHDOG_CYCLES = 5000;
  // settling time after the last result: covers the divider and the end path
  localparam int DRAIN_CYCLES    = 60;
  // random transactions per idling phase (three phases)
  localparam int PHASE_ITEMS     = 550;
  localparam int N_DIRECTED      = 26;

  // one result transaction as the evaluator reports it
  typedef struct packed {
    logic signed [31:0] value;
    pfx_pkg::status_t   status;
  } eval_result_t;

  // one row of the directed stimulus; typed rows carry their result
  typedef struct packed {
    logic [7:0]         ch;
    logic               fin;
    logic               typed;
    logic signed [31:0] value;
    pfx_pkg::status_t   status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pfx_in_if  in_ch();
  pfx_out_if out_ch();

  postfix_expression_evaluator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // idling rates in percent, changed per phase
  int unsigned src_idle_pct   = 6;
  int unsigned sink_stall_pct = 77;

  // results still owed by the evaluator, oldest first
  eval_result_t pending_results[$];
  int unsigned  fail_count    = 0;
  int unsigned  counted_items = 0;
  int unsigned  quiet_cycles  = 0;
  // last accepted character was a digit, so a new number needs a separator
  bit           prev_digit    = 1'b0;

  // shadow copy of the evaluator state
  logic [31:0]      model_stack [pfx_pkg::STACK_DEPTH];
  int unsigned      model_depth   = 0;
  logic [31:0]      model_acc     = '0;
  bit               model_pending = 1'b0;
  pfx_pkg::status_t model_err     = pfx_pkg::ST_OK;

  // ---------------------------------------------------------------------------
  // directed stimulus: empty expression, leftovers below the top, operator on
  // an empty stack, divide by zero, subtract and multiply with a pending number,
  // divide then an unknown character popping the stack empty
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [N_DIRECTED] = '{
    // end on an empty stack, character byte at its low extreme
    '{8'h00,                   1'b1, 1'b1, 32'sd0, pfx_pkg::ST_UNDERFLOW},
    // "1 7": the 1 stays below, the 7 is reported
    '{pfx_pkg::CH_ZERO + 8'd1, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_SPACE,       1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_PLUS,        1'b1, 1'b1, 32'sd7, pfx_pkg::ST_OK},
    // "+": operator with nothing to pop
    '{pfx_pkg::CH_PLUS,        1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{8'hFF,                   1'b1, 1'b1, 32'sd0, pfx_pkg::ST_UNDERFLOW},
    // "8 0/": divisor zero
    '{pfx_pkg::CH_ZERO + 8'd8, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_SPACE,       1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_ZERO,        1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_SLASH,       1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_ZERO,        1'b1, 1'b1, 32'sd0, pfx_pkg::ST_DIVZERO},
    // "9 5-3*": pending 3 flushed by the multiply
    '{pfx_pkg::CH_ZERO + 8'd9, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_SPACE,       1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_ZERO + 8'd5, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_MINUS,       1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_ZERO + 8'd3, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_STAR,        1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_SLASH,       1'b1, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    // "5 2/4" then byte ff: unknown character pops both and pushes nothing
    '{pfx_pkg::CH_ZERO + 8'd5, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_SPACE,       1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_ZERO + 8'd2, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_SLASH,       1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_ZERO + 8'd4, 1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{8'hFF,                   1'b0, 1'b0, 32'sd0, pfx_pkg::ST_OK},
    '{pfx_pkg::CH_SPACE,       1'b1, 1'b0, 32'sd0, pfx_pkg::ST_OK}
  };

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // only the first error of an expression is kept
  function automatic void latch_first_error(input pfx_pkg::status_t code);
    if (model_err == pfx_pkg::ST_OK) model_err = code;
  endfunction

  function automatic void push_operand(input logic [31:0] v);
    if (model_depth >= pfx_pkg::STACK_DEPTH) begin
      latch_first_error(pfx_pkg::ST_OVERFLOW);
    end else begin
      model_stack[model_depth] = v;
      model_depth++;
    end
  endfunction

  function automatic void finish_number();
    if (model_pending) begin
      push_operand(model_acc);
      model_pending = 1'b0;
      model_acc     = '0;
    end
  endfunction

  // advance the shadow state by one character transaction; an end
  // transaction yields a result and clears the whole state
  task automatic predict_transaction(input logic [7:0] ch, input logic fin,
                                     output bit produces, output eval_result_t res);
    logic [31:0] rhs, lhs, mag_l, mag_r, quot;
    produces = 1'b0;
    res      = '0;
    if (fin) begin
      if (model_err == pfx_pkg::ST_OK) finish_number();
      if (model_err == pfx_pkg::ST_OK) begin
        if (model_depth == 0) latch_first_error(pfx_pkg::ST_UNDERFLOW);
        else res.value = model_stack[model_depth-1];
      end
      if (model_err != pfx_pkg::ST_OK) res.value = '0;
      res.status    = model_err;
      produces      = 1'b1;
      model_depth   = 0;
      model_acc     = '0;
      model_pending = 1'b0;
      model_err     = pfx_pkg::ST_OK;
    end else if (model_err == pfx_pkg::ST_OK) begin
      if (ch inside {[pfx_pkg::CH_ZERO:pfx_pkg::CH_NINE]}) begin
        // decimal accumulate, wrapping at 32 bits
        model_acc     = model_acc * 32'd10 + 32'(ch - pfx_pkg::CH_ZERO);
        model_pending = 1'b1;
      end else begin
        finish_number();
        if (ch != pfx_pkg::CH_SPACE && model_err == pfx_pkg::ST_OK) begin
          if (model_depth < 2) begin
            latch_first_error(pfx_pkg::ST_UNDERFLOW);
            model_depth = 0;
          end else begin
            rhs = model_stack[model_depth-1];
            lhs = model_stack[model_depth-2];
            model_depth -= 2;
            case (ch)
              pfx_pkg::CH_PLUS:  push_operand(lhs + rhs);
              pfx_pkg::CH_MINUS: push_operand(lhs - rhs);
              pfx_pkg::CH_STAR:  push_operand(lhs * rhs);
              pfx_pkg::CH_SLASH: begin
                if (rhs == '0) begin
                  latch_first_error(pfx_pkg::ST_DIVZERO);
                end else begin
                  // magnitudes, then sign: truncation toward zero, min / -1 wraps
                  mag_l = lhs[31] ? 32'd0 - lhs : lhs;
                  mag_r = rhs[31] ? 32'd0 - rhs : rhs;
                  quot  = mag_l / mag_r;
                  push_operand((lhs[31] ^ rhs[31]) ? 32'd0 - quot : quot);
                end
              end
              default: ;  // unknown character: both operands dropped
            endcase
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // input channel driver
  // ---------------------------------------------------------------------------

  // offer one transaction, wait until it is taken, then record the result
  // it is bound to produce (typed rows bring their own)
  task automatic send_item(input logic [7:0] ch, input logic fin,
                           input bit use_typed = 1'b0,
                           input eval_result_t typed_result = '0);
    bit           produces;
    eval_result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.character  <= ch;
    in_ch.end_marker <= fin;
    do @(posedge clk); while (!in_ch.ready);
    counted_items++;
    prev_digit = !fin && (ch inside {[pfx_pkg::CH_ZERO:pfx_pkg::CH_NINE]});
    predict_transaction(ch, fin, produces, predicted);
    if (produces) pending_results.push_back(use_typed ? typed_result : predicted);
  endtask

  // decimal digits of an unsigned value, most significant first
  task automatic send_decimal(input logic [31:0] v);
    logic [7:0]  digit_chars[$];
    logic [31:0] rest;
    rest = v;
    do begin
      digit_chars.push_front(pfx_pkg::CH_ZERO + 8'(rest % 32'd10));
      rest = rest / 32'd10;
    end while (rest != '0);
    foreach (digit_chars[k]) send_item(digit_chars[k], 1'b0);
  endtask

  // one number with a separator in front if needed; mostly small values,
  // some full range, the signed extremes, and over-long runs that wrap
  task automatic send_operand();
    int unsigned kind;
    int unsigned run_len;
    kind = $urandom_range(99);
    if (prev_digit) send_item(pfx_pkg::CH_SPACE, 1'b0);
    if (kind < 40) begin
      send_decimal($urandom_range(9));
    end else if (kind < 65) begin
      send_decimal($urandom_range(999));
    end else if (kind < 80) begin
      send_decimal($urandom());
    end else if (kind < 92) begin
      case ($urandom_range(3))
        0:       send_decimal(32'h8000_0000);
        1:       send_decimal(32'hFFFF_FFFF);
        2:       send_decimal(32'h7FFF_FFFF);
        default: send_decimal(32'd0);
      endcase
    end else begin
      run_len = $urandom_range(14, 11);
      repeat (run_len) send_item(pfx_pkg::CH_ZERO + 8'($urandom_range(9)), 1'b0);
    end
  endtask

  // arithmetic operators with the odd unknown byte mixed in
  function automatic logic [7:0] pick_operator();
    int unsigned r;
    logic [7:0]  c;
    r = $urandom_range(99);
    if (r < 28) return pfx_pkg::CH_PLUS;
    if (r < 50) return pfx_pkg::CH_MINUS;
    if (r < 72) return pfx_pkg::CH_STAR;
    if (r < 94) return pfx_pkg::CH_SLASH;
    do c = 8'($urandom_range(255));
    while (c inside {[pfx_pkg::CH_ZERO:pfx_pkg::CH_NINE], pfx_pkg::CH_SPACE,
                     pfx_pkg::CH_PLUS, pfx_pkg::CH_MINUS, pfx_pkg::CH_STAR,
                     pfx_pkg::CH_SLASH});
    return c;
  endfunction

  // hold the input channel until every owed result has come back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result channel: random back-pressure and in-order check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : check_results
    eval_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: value %0d status %0d",
               out_ch.value, out_ch.status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.value !== want.value) begin
          $error("value mismatch: expected %0d, actual %0d", want.value, out_ch.value);
          fail_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_ch.status);
          fail_count++;
        end
      end
    end
  end

  // watchdog: no transaction on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mode;
    bit          deep;
    int unsigned cap;
    int unsigned ops_left;
    int unsigned depth_est;

    in_ch.valid      = 1'b0;
    in_ch.character  = '0;
    in_ch.end_marker = 1'b0;
    out_ch.ready     = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r])
      send_item(directed_rows[r].ch, directed_rows[r].fin, directed_rows[r].typed,
                eval_result_t'{directed_rows[r].value, directed_rows[r].status});
    wait_for_results();

    counted_items = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 6;  sink_stall_pct = 77; end
        1: begin src_idle_pct = 77; sink_stall_pct = 6;  end
        default: begin src_idle_pct = 0; sink_stall_pct = 0; end
      endcase

      while (counted_items < (phase + 1) * PHASE_ITEMS) begin
        mode = $urandom_range(99);
        if (mode < 78) begin
          // well-formed expression; deep ones fill the stack and may overflow
          deep      = ($urandom_range(99) < 12);
          cap       = deep ? $urandom_range(pfx_pkg::STACK_DEPTH + 1,
                                            pfx_pkg::STACK_DEPTH - 2)
                           : $urandom_range(6, 2);
          ops_left  = deep ? $urandom_range(20, 1) : $urandom_range(6, 1);
          depth_est = 0;
          while (ops_left != 0) begin
            if (depth_est < 2 || (depth_est < cap && (deep || $urandom_range(1) == 1))) begin
              send_operand();
              depth_est++;
            end else begin
              if ($urandom_range(4) == 0) send_item(pfx_pkg::CH_SPACE, 1'b0);
              send_item(pick_operator(), 1'b0);
              depth_est--;
              ops_left--;
            end
          end
          send_item(8'($urandom_range(255)), 1'b1);
        end else if (mode < 81) begin
          // most negative value over minus one wraps onto itself
          send_decimal(32'h8000_0000);
          send_item(pfx_pkg::CH_SPACE, 1'b0);
          send_decimal(32'hFFFF_FFFF);
          send_item(pfx_pkg::CH_SLASH, 1'b0);
          send_item(8'($urandom_range(255)), 1'b1);
        end else if (mode < 91) begin
          // broken sequence: tokens in any order, possibly none at all
          repeat ($urandom_range(10, 0)) begin
            case ($urandom_range(3))
              0, 1:    send_operand();
              2:       send_item(pick_operator(), 1'b0);
              default: send_item(pfx_pkg::CH_SPACE, 1'b0);
            endcase
          end
          send_item(8'($urandom_range(255)), 1'b1);
        end else begin
          // raw byte noise
          repeat ($urandom_range(8, 1)) send_item(8'($urandom_range(255)), 1'b0);
          send_item(8'($urandom_range(255)), 1'b1);
        end
      end

      // sender holds off until the evaluator has caught up
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pfx_pkg.sv
rtl/pfx_ifs.sv
rtl/pfx_div.sv
rtl/postfix_expression_evaluator.sv
sim/testbench.sv
